>>> sv/polyline_arc_length_resampler_assert.svh
// Assertion macros shared by the resampler RTL.
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define PALR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palr assertion failed");
`define PALR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palr assertion failed");
`else
`define PALR_ASSERT_IMP(label, clk, rst, ante, cons)
`define PALR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/palr_pkg.sv
package palr_pkg;
   localparam int CoordW   = 16;
   localparam int LenW     = 26;
   localparam int SqW      = 35;
   localparam int SqrtTop  = 32;
   localparam int RootW    = 18;
   localparam int NumW     = 44;
   localparam int CfgW     = 7;
   localparam int IdxW     = 6;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 32;

   localparam logic [CsrAddrW-1:0] CsrAddrSampleCount = 2'd0;
   localparam logic [CfgW-1:0]     SampleCountReset   = 7'd16;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
      logic                     last_point;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] sample_x;
      logic signed [CoordW-1:0] sample_y;
      logic signed [CoordW-1:0] sample_z;
      logic [IdxW-1:0]          sample_index;
      logic                     truncated;
      logic                     last_sample;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } queue_type;
endpackage

>>> sv/palr_req_if.sv
interface palr_req_if;
   import palr_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> sv/palr_rsp_if.sv
interface palr_rsp_if;
   import palr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> sv/polyline_arc_length_resampler.sv
// A point is taken when the back end is idle; the first point of a curve goes straight to a
// write, each later one to three squarings, a 17-step square root and a write, one at a time.
// An end sample or a sample of a one-point curve reads one stored point; an inner sample
// searches the stored lengths and makes four passes of the 44-step divider.
// Synchronous reset clears control state and sets sample_count to 16; the point and
// length memories are not cleared.
`include "polyline_arc_length_resampler_assert.svh"
module polyline_arc_length_resampler #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   palr_req_if.sink                      req_chan,
   palr_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [palr_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [palr_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [palr_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);
   import palr_pkg::*;

   logic [CfgW-1:0] sample_count_ff, sample_count_in;
   logic            csr_write;
   queue_type       q;
   logic            q_ready;
   logic            first_sample;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CsrAddrSampleCount);
   assign csr_prdata = (csr_paddr == CsrAddrSampleCount) ?
                       CsrDataW'(sample_count_ff) : '0;
   assign sample_count_in = csr_write ? csr_pwdata[CfgW-1:0] : sample_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SampleCountReset;
      end else begin
         sample_count_ff <= sample_count_in;
      end
   end

   palr_front u_front (
      .clock(clock), .reset(reset), .req(req_chan), .q_out(q), .q_ready(q_ready)
   );

   palr_back #(.MAX_POINTS(MAX_POINTS), .MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock(clock), .reset(reset), .q_in(q), .q_ready(q_ready),
      .sample_count(sample_count_ff), .rsp(rsp_chan)
   );

   assign first_sample = rsp_chan.valid && (rsp_chan.data.sample_index == '0);

   `PALR_ASSERT_IMP(a_first_not_last, clock, reset, first_sample, !rsp_chan.data.last_sample)
   `PALR_ASSERT_NXT(a_csr_write, clock, reset, csr_write, sample_count_ff == $past(csr_pwdata[CfgW-1:0]))
endmodule

>>> sv/palr_ram.sv
module palr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/palr_front.sv
module palr_front (
   input  logic             clock,
   input  logic             reset,
   palr_req_if.sink         req,
   output palr_pkg::queue_type q_out,
   input  logic             q_ready
);
   import palr_pkg::*;

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign pop  = q_out.valid && q_ready;
   assign q_out = '{valid: (cnt_ff != 2'd0), data: entry_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req.data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

>>> sv/palr_div.sv
module palr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [palr_pkg::NumW-1:0] num,
   input  logic [palr_pkg::LenW-1:0] den,
   output logic                      done,
   output logic [palr_pkg::NumW-1:0] quot
);
   import palr_pkg::*;
   localparam int CntW = $clog2(NumW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumW-1:0] num_ff, num_in;
   logic [NumW-1:0] quot_ff, quot_in;
   logic [LenW-1:0] rem_ff, rem_in;
   logic [LenW-1:0] den_ff, den_in;
   logic [LenW:0]   trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NumW-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(NumW);
         num_in  = num;
         quot_in = '0;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? LenW'(trial - {1'b0, den_ff}) : trial[LenW-1:0];
         quot_in = {quot_ff[NumW-2:0], ge};
         num_in  = {num_ff[NumW-2:0], 1'b0};
         cnt_in  = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

>>> sv/palr_back.sv
module palr_back #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  palr_pkg::queue_type       q_in,
   output logic                      q_ready,
   input  logic [palr_pkg::CfgW-1:0] sample_count,
   palr_rsp_if.source                rsp
);
   import palr_pkg::*;
   localparam int AddrW = $clog2(MAX_POINTS);
   localparam int CntW  = $clog2(MAX_POINTS + 1);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_SQ      = 16'h0002,
      ST_SQRT    = 16'h0004,
      ST_WRITE   = 16'h0008,
      ST_SETUP   = 16'h0010,
      ST_SAMPLE  = 16'h0020,
      ST_TDIV    = 16'h0040,
      ST_SRCH_RD = 16'h0080,
      ST_SRCH_CK = 16'h0100,
      ST_RD_PREV = 16'h0200,
      ST_RD_CUR  = 16'h0400,
      ST_LERP    = 16'h0800,
      ST_MUL     = 16'h1000,
      ST_LDIV    = 16'h2000,
      ST_LWAIT   = 16'h4000,
      ST_EMIT    = 16'h8000
   } state_type;

   function automatic logic signed [CoordW-1:0] get_axis(point_type p, logic [1:0] a);
      logic signed [CoordW-1:0] v;
      case (a)
         2'd0:    v = p.x;
         2'd1:    v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

   function automatic point_type set_axis(point_type p, logic [1:0] a,
                                          logic signed [CoordW-1:0] v);
      point_type r;
      r = p;
      case (a)
         2'd0:    r.x = v;
         2'd1:    r.y = v;
         default: r.z = v;
      endcase
      return r;
   endfunction

   state_type                state_ff, state_in;
   req_type                  cur_ff, cur_in;
   point_type                prev_ff, prev_in;
   logic [LenW-1:0]          cum_last_ff, cum_last_in;
   logic [CntW-1:0]          count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [1:0]               axis_ff, axis_in;
   logic [SqW-1:0]           acc_ff, acc_in;
   logic [SqW-1:0]           root_ff, root_in;
   logic [SqW-1:0]           bit_ff, bit_in;
   logic [CfgW-1:0]          s_ff, s_in;
   logic [IdxW-1:0]          i_ff, i_in;
   logic [AddrW-1:0]         k_ff, k_in;
   logic [LenW-1:0]          target_ff, target_in;
   logic [LenW-1:0]          ck_ff, ck_in;
   logic [LenW-1:0]          ckm_ff, ckm_in;
   logic [LenW-1:0]          seg_ff, seg_in;
   logic [LenW-1:0]          d_ff, d_in;
   point_type                pa_ff, pa_in;
   point_type                pb_ff, pb_in;
   point_type                res_ff, res_in;
   logic signed [NumW-1:0]   prod_ff, prod_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_ff, out_in;

   point_type                cur_pt;
   logic signed [CoordW-1:0] cur_ax;
   logic signed [CoordW-1:0] prev_ax;
   logic signed [CoordW-1:0] pa_ax;
   logic signed [CoordW-1:0] pb_ax;
   logic signed [CoordW:0]   sq_diff;
   logic signed [2*CoordW+1:0] sq_prod;
   logic [SqW-1:0]           trial;
   logic [LenW:0]            cum_sum;
   logic [LenW-1:0]          cum_wr;
   logic                     last_i;
   logic signed [CoordW:0]   lerp_diff;
   logic signed [LenW:0]     d_signed;
   logic [NumW-1:0]          mag;
   logic [CoordW:0]          q_val;
   logic [CoordW:0]          pa_ext;
   logic [CoordW:0]          res_val;
   logic [LenW:0]            gap;

   logic                     we;
   logic [AddrW-1:0]         waddr;
   logic [AddrW-1:0]         raddr;
   point_type                pt_rd;
   logic [LenW-1:0]          cum_rd;
   logic                     div_start;
   logic [NumW-1:0]          div_num;
   logic [LenW-1:0]          div_den;
   logic                     div_done;
   logic [NumW-1:0]          div_q;

   palr_ram #(.WIDTH(3 * CoordW), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(cur_pt),
      .raddr(raddr), .rdata(pt_rd)
   );

   palr_ram #(.WIDTH(LenW), .DEPTH(MAX_POINTS)) u_cum_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(cum_wr),
      .raddr(raddr), .rdata(cum_rd)
   );

   palr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q)
   );

   assign cur_pt   = '{x: cur_ff.point_x, y: cur_ff.point_y, z: cur_ff.point_z};
   assign cur_ax   = get_axis(cur_pt, axis_ff);
   assign prev_ax  = get_axis(prev_ff, axis_ff);
   assign pa_ax    = get_axis(pa_ff, axis_ff);
   assign pb_ax    = get_axis(pb_ff, axis_ff);
   assign sq_diff  = {cur_ax[CoordW-1], cur_ax} - {prev_ax[CoordW-1], prev_ax};
   assign sq_prod  = sq_diff * sq_diff;
   assign trial    = root_ff + bit_ff;
   assign cum_sum  = {1'b0, cum_last_ff} + (LenW + 1)'(root_ff[RootW-1:0]);
   assign cum_wr   = (count_ff == '0) ? '0 :
                     (cum_sum[LenW] ? {LenW{1'b1}} : cum_sum[LenW-1:0]);
   assign last_i   = ({1'b0, i_ff} == (s_ff - CfgW'(1)));
   assign lerp_diff = {pb_ax[CoordW-1], pb_ax} - {pa_ax[CoordW-1], pa_ax};
   assign d_signed = $signed({1'b0, d_ff});
   assign mag      = (prod_ff[NumW-1] ? NumW'(-prod_ff) : NumW'(prod_ff))
                     + NumW'(seg_ff >> 1);
   assign q_val    = prod_ff[NumW-1] ? -div_q[CoordW:0] : div_q[CoordW:0];
   assign pa_ext   = {pa_ax[CoordW-1], pa_ax};
   assign res_val  = pa_ext + q_val;
   assign gap      = {1'b0, target_ff} - {1'b0, ckm_ff};
   assign q_ready  = (state_ff == ST_IDLE);
   assign waddr    = count_ff[AddrW-1:0];
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      cum_last_in  = cum_last_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      s_in         = s_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      target_in    = target_ff;
      ck_in        = ck_ff;
      ckm_in       = ckm_ff;
      seg_in       = seg_ff;
      d_in         = d_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      res_in       = res_ff;
      prod_in      = prod_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      we           = 1'b0;
      raddr        = k_ff;
      div_start    = 1'b0;
      div_num      = NumW'(cum_last_ff) * NumW'(i_ff);
      div_den      = LenW'(s_ff - CfgW'(1));
      unique case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               cur_in = q_in.data;
               if (count_ff == CntW'(MAX_POINTS)) begin
                  ovf_in   = 1'b1;
                  state_in = q_in.data.last_point ? ST_SETUP : ST_IDLE;
               end else if (count_ff == '0) begin
                  root_in  = '0;
                  state_in = ST_WRITE;
               end else begin
                  acc_in   = '0;
                  axis_in  = 2'd0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            acc_in  = acc_ff + SqW'($unsigned(sq_prod));
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = SqW'(1) << SqrtTop;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               if (acc_ff >= trial) begin
                  acc_in  = acc_ff - trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_WRITE: begin
            we          = 1'b1;
            prev_in     = cur_pt;
            cum_last_in = cum_wr;
            count_in    = count_ff + CntW'(1);
            state_in    = cur_ff.last_point ? ST_SETUP : ST_IDLE;
         end
         ST_SETUP: begin
            if (sample_count < CfgW'(2)) begin
               s_in = CfgW'(2);
            end else if (sample_count > CfgW'(MAX_SAMPLES)) begin
               s_in = CfgW'(MAX_SAMPLES);
            end else begin
               s_in = sample_count;
            end
            i_in     = '0;
            k_in     = AddrW'(1);
            state_in = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            if (i_ff == '0 || count_ff < CntW'(2)) begin
               raddr    = '0;
               state_in = ST_RD_PREV;
            end else if (last_i) begin
               raddr    = AddrW'(count_ff - CntW'(1));
               state_in = ST_RD_PREV;
            end else begin
               div_start = 1'b1;
               state_in  = ST_TDIV;
            end
            if (i_ff == '0 || count_ff < CntW'(2) || last_i) begin
               k_in = AddrW'(0);
            end
         end
         ST_TDIV: begin
            if (div_done) begin
               target_in = div_q[LenW-1:0];
               state_in  = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CK;
         end
         ST_SRCH_CK: begin
            if ((CntW'(k_ff) < count_ff - CntW'(1)) && (cum_rd < target_ff)) begin
               k_in     = k_ff + AddrW'(1);
               state_in = ST_SRCH_RD;
            end else begin
               ck_in    = cum_rd;
               raddr    = k_ff - AddrW'(1);
               state_in = ST_RD_CUR;
            end
         end
         ST_RD_PREV: begin
            res_in   = pt_rd;
            state_in = ST_EMIT;
         end
         ST_RD_CUR: begin
            ckm_in   = cum_rd;
            pa_in    = pt_rd;
            state_in = ST_LERP;
         end
         ST_LERP: begin
            pb_in  = pt_rd;
            seg_in = ck_ff - ckm_ff;
            if (ck_ff == ckm_ff) begin
               res_in   = pa_ff;
               state_in = ST_EMIT;
            end else begin
               if (gap[LenW]) begin
                  d_in = '0;
               end else if (gap[LenW-1:0] > (ck_ff - ckm_ff)) begin
                  d_in = ck_ff - ckm_ff;
               end else begin
                  d_in = gap[LenW-1:0];
               end
               axis_in  = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = lerp_diff * d_signed;
            state_in = ST_LDIV;
         end
         ST_LDIV: begin
            div_start = 1'b1;
            div_num   = mag;
            div_den   = seg_ff;
            state_in  = ST_LWAIT;
         end
         ST_LWAIT: begin
            if (div_done) begin
               res_in  = set_axis(res_ff, axis_ff, res_val[CoordW-1:0]);
               axis_in = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd2) ? ST_EMIT : ST_MUL;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in        = 1'b1;
               out_in.sample_x     = res_ff.x;
               out_in.sample_y     = res_ff.y;
               out_in.sample_z     = res_ff.z;
               out_in.sample_index = i_ff;
               out_in.truncated    = ovf_ff;
               out_in.last_sample  = last_i;
               if (last_i) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  k_in     = (k_ff == '0) ? AddrW'(1) : k_ff;
                  state_in = ST_SAMPLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_SRCH_RD) begin
         raddr = k_ff;
      end else if (state_ff == ST_LERP || state_ff == ST_RD_CUR) begin
         raddr = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      cum_last_ff <= cum_last_in;
      axis_ff     <= axis_in;
      acc_ff      <= acc_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      s_ff        <= s_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      target_ff   <= target_in;
      ck_ff       <= ck_in;
      ckm_ff      <= ckm_in;
      seg_ff      <= seg_in;
      d_ff        <= d_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      out_ff      <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule
